/* hw/rtl/b58_pkg.sv */
`default_nettype none
package b58_pkg;

  // Counter width for byte and leading-zero counts (counts up to 63)
  localparam int CNT_W = 6;

  // Most characters ever emitted for one message
  localparam int RESULT_CAP = 45;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // ASCII code of the character '1' (leading zero byte)
  localparam logic [6:0] ONE_CHAR = 7'd49;

  // Bitcoin alphabet, first character in the highest byte
  localparam logic [8*58-1:0] ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  // One unit of work for the back end
  typedef struct packed {
    logic             do_acc;    // fold data_byte into the digit store
    logic [7:0]       data_byte;
    logic             last;      // message ends with this command
    logic             too_long;  // message overflowed
    logic [CNT_W-1:0] lz_count;  // leading zero bytes so far
  } cmd_t;

  // Map a base-58 digit to its ASCII code
  function automatic logic [6:0] b58_char(input logic [5:0] d);
    logic [5:0] k;
    k = 6'd57 - d;
    if (d < 6'd58) begin
      return ALPHABET[{k, 3'b000} +: 7];
    end
    return 7'd0;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/b58_front.sv */
`default_nettype none
module b58_front #(
  parameter int MAX_BYTES = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // [7:0] data_byte
  input  wire logic          s_tlast,   // last_byte
  input  wire logic          q_full,
  output logic               q_push,
  output b58_pkg::cmd_t      q_cmd
);
  import b58_pkg::*;

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [CNT_W-1:0] lz_count, lz_count_next;
  logic             seen_nonzero, seen_nonzero_next;
  logic             overflow, overflow_next;
  logic             accept;
  logic             do_acc;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Classify the incoming byte
  always_comb begin
    byte_count_next   = byte_count;
    lz_count_next     = lz_count;
    seen_nonzero_next = seen_nonzero;
    overflow_next     = overflow;
    do_acc            = 1'b0;
    if (!overflow) begin
      if (byte_count >= CNT_W'(MAX_BYTES)) begin
        overflow_next = 1'b1;
      end else begin
        byte_count_next = byte_count + 1'b1;
        if (!seen_nonzero && s_tdata == 8'd0) begin
          lz_count_next = lz_count + 1'b1;
        end else begin
          seen_nonzero_next = 1'b1;
          do_acc            = 1'b1;
        end
      end
    end
  end

  // Only bytes that touch the digit store or end the message go downstream
  assign q_push         = accept && (do_acc || s_tlast);
  assign q_cmd.do_acc    = do_acc;
  assign q_cmd.data_byte = s_tdata;
  assign q_cmd.last      = s_tlast;
  assign q_cmd.too_long  = overflow_next;
  assign q_cmd.lz_count  = lz_count_next;

  // Per-message counters, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      lz_count     <= '0;
      seen_nonzero <= 1'b0;
      overflow     <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_count   <= '0;
        lz_count     <= '0;
        seen_nonzero <= 1'b0;
        overflow     <= 1'b0;
      end else begin
        byte_count   <= byte_count_next;
        lz_count     <= lz_count_next;
        seen_nonzero <= seen_nonzero_next;
        overflow     <= overflow_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/b58_cmdq.sv */
`default_nettype none
module b58_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  b58_pkg::cmd_t      push_cmd,
  output logic               full,
  input  wire logic          pop,
  output b58_pkg::cmd_t      pop_cmd,
  output logic               not_empty
);
  import b58_pkg::*;

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  do_push, do_pop;

  assign full      = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/b58_back.sv */
`default_nettype none
module b58_back #(
  parameter int MAX_DIGITS = 45
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  b58_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,   // [6:0] char_code, [7] zero
  output logic               m_tlast,   // last_char
  output logic               m_tuser    // too_long
);
  import b58_pkg::*;

  localparam int IW = $clog2(MAX_DIGITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_ONES = 3'd3;
  localparam logic [2:0] S_DIG  = 3'd4;
  localparam logic [2:0] S_FLAG = 3'd5;

  logic [2:0]       state, state_next;
  logic [IW-1:0]    pos, pos_next;
  logic [7:0]       carry, carry_next;
  logic             pass_nz, pass_nz_next;
  logic             val_nz, val_nz_next;
  logic             skip, skip_next;
  logic [CNT_W-1:0] ones_left, ones_left_next;
  logic [CNT_W-1:0] n_out, n_out_next;
  cmd_t             cmd, cmd_next;

  // Digit store with per-entry valid bits
  logic [5:0]          mem [MAX_DIGITS];
  logic [MAX_DIGITS-1:0] valid;
  logic [5:0]          rdata;
  logic                rd_vld;
  logic [5:0]          digit;
  logic                we;
  logic                clr;

  // Output register
  logic       out_free;
  logic       load;
  logic [6:0] load_char;
  logic       load_last;
  logic       load_too;
  logic [6:0] out_char;

  // Multiply-by-256-and-add datapath for one digit
  logic [10:0] u;
  logic [25:0] prod;
  logic [4:0]  q_u;
  logic [10:0] r_wide;
  logic [5:0]  r;
  logic [7:0]  q;
  logic        cap_hit;

  assign digit = rd_vld ? rdata : 6'd0;

  // 256*d + c = 58*(4d) + (24d + c); divide the small part by 58 via reciprocal
  assign u      = 11'(carry) + 11'(digit) * 11'd24;
  assign prod   = 26'(u) * 26'd18079;
  assign q_u    = prod[24:20];
  assign r_wide = u - ((11'(q_u) << 6) - (11'(q_u) << 3) + (11'(q_u) << 1));
  assign r      = r_wide[5:0];
  assign q      = {digit, 2'b00} + 8'(q_u);

  assign out_free = !m_tvalid || m_tready;
  assign cap_hit  = (n_out == CNT_W'(RESULT_CAP-1));

  // Sequencer
  always_comb begin
    state_next     = state;
    pos_next       = pos;
    carry_next     = carry;
    pass_nz_next   = pass_nz;
    val_nz_next    = val_nz;
    skip_next      = skip;
    ones_left_next = ones_left;
    n_out_next     = n_out;
    cmd_next       = cmd;
    q_pop          = 1'b0;
    we             = 1'b0;
    clr            = 1'b0;
    load           = 1'b0;
    load_char      = 7'd0;
    load_last      = 1'b0;
    load_too       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          cmd_next = q_cmd;
          if (q_cmd.do_acc) begin
            state_next   = S_ACC;
            pos_next     = IW'(MAX_DIGITS-1);
            carry_next   = q_cmd.data_byte;
            pass_nz_next = 1'b0;
          end else begin
            state_next = S_PREP;
            pos_next   = '0;
          end
        end
      end
      S_ACC: begin
        we           = 1'b1;
        carry_next   = q;
        pass_nz_next = pass_nz || (r != 6'd0);
        if (pos == '0) begin
          val_nz_next = pass_nz || (r != 6'd0);
          state_next  = cmd.last ? S_PREP : S_IDLE;
        end else begin
          pos_next = pos - 1'b1;
        end
      end
      S_PREP: begin
        pos_next       = '0;
        ones_left_next = cmd.lz_count;
        n_out_next     = '0;
        skip_next      = 1'b1;
        if (cmd.too_long) begin
          state_next = S_FLAG;
        end else if (cmd.lz_count != '0) begin
          state_next = S_ONES;
        end else if (val_nz) begin
          state_next = S_DIG;
        end else begin
          clr         = 1'b1;
          val_nz_next = 1'b0;
          state_next  = S_IDLE;
        end
      end
      S_ONES: begin
        if (out_free) begin
          load           = 1'b1;
          load_char      = ONE_CHAR;
          load_last      = (ones_left == CNT_W'(1) && !val_nz) || cap_hit;
          ones_left_next = ones_left - 1'b1;
          n_out_next     = n_out + 1'b1;
          if (load_last) begin
            clr         = 1'b1;
            val_nz_next = 1'b0;
            state_next  = S_IDLE;
          end else if (ones_left == CNT_W'(1)) begin
            state_next = S_DIG;
          end
        end
      end
      S_DIG: begin
        if (skip && digit == 6'd0) begin
          pos_next = pos + 1'b1;
        end else if (out_free) begin
          load       = 1'b1;
          load_char  = b58_char(digit);
          load_last  = (pos == IW'(MAX_DIGITS-1)) || cap_hit;
          skip_next  = 1'b0;
          n_out_next = n_out + 1'b1;
          if (load_last) begin
            clr         = 1'b1;
            val_nz_next = 1'b0;
            state_next  = S_IDLE;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
      end
      S_FLAG: begin
        if (out_free) begin
          load        = 1'b1;
          load_too    = 1'b1;
          clr         = 1'b1;
          val_nz_next = 1'b0;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pos    <= '0;
      val_nz <= 1'b0;
    end else begin
      state  <= state_next;
      pos    <= pos_next;
      val_nz <= val_nz_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    carry     <= carry_next;
    pass_nz   <= pass_nz_next;
    skip      <= skip_next;
    ones_left <= ones_left_next;
    n_out     <= n_out_next;
    cmd       <= cmd_next;
  end

  // Digit memory: one write, one registered read at the next position
  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= r;
    end
    rdata <= mem[pos_next];
  end

  // Valid bits: cleared at reset and at the end of every message
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
    end else if (we) begin
      valid[pos] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= valid[pos_next];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char <= load_char;
      m_tlast  <= load_last;
      m_tuser  <= load_too;
    end
  end

  assign m_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

/* hw/rtl/base58_encode_bytes_core.sv */
// Base58 (Bitcoin alphabet) encoder, one message byte per input transfer.
//
// Input stream: s_tdata carries one message byte, most significant first;
// s_tlast marks the final byte. Output stream: one ASCII character per
// transfer in m_tdata[6:0], m_tlast on the final character, m_tuser set on
// the single zero result that reports a message longer than MAX_BYTES.
//
// The front end counts bytes and leading zeros and queues work in a two-entry
// command queue, so it keeps taking bytes while the back end is busy. The back
// end holds MAX_DIGITS base-58 digits in a single-port-write memory and folds
// each nonzero-led byte in with one digit per cycle. Leading zero bytes take
// only their input transfer and reach the back end only when one ends the
// message. After the last byte and a setup state (S_PREP), the characters
// come out at one per cycle while m_tready does not stall them; the back end
// steps over skipped leading zero digits without emitting a character.
//
// Reset clears the front counters, queue, sequencer state, digit valid bits
// and m_tvalid; no clearing pass is needed. A stalled m_tready holds the
// character and stalls output; the front accepts until the queue is full.
`default_nettype none
module base58_encode_bytes_core #(
  parameter int MAX_BYTES  = 32,
  parameter int MAX_DIGITS = 45
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [6:0] char_code, [7] zero
  output logic            m_tlast,   // last_char
  output logic            m_tuser    // too_long
);
  import b58_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  b58_front #(
    .MAX_BYTES(MAX_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  b58_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .not_empty (not_empty)
  );

  b58_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (not_empty),
    .q_cmd    (pop_cmd),
    .q_pop    (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* hw/rtl/b58_checker.sv */
`default_nettype none
module b58_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // A stalled result keeps its contents
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

  // The overflow report carries a zero code and no end mark
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 8'd0 && !m_tlast)
    else $error("bad overflow report");

  // Every character is printable ASCII from the alphabet range
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tdata[7] && m_tdata >= 8'd49 && m_tdata <= 8'd122)
    else $error("character out of range");

  // Nothing is offered right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result offered after reset");

endmodule

bind base58_encode_bytes_core b58_checker u_chk (.*);
`default_nettype wire
